>>> rtl/core/tcs_pkg.sv
// ----------------------------------------------------------------------------
// Ternary census signature: shared package
// Pixel, position and signature widths, powers of three, the register map
// and the patch record handed from the window front end to the census
// datapath.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int PIX_W  = 8;   // grey pixel
    localparam int POS_W  = 10;  // centre column / row on the result
    localparam int SIG_W  = 26;  // base-3 signature
    localparam int NB_NUM = 16;  // neighbours per centre
    localparam int GRP_W  = 7;   // four base-3 digits, below 81

    // powers of three used to join the four digit groups
    localparam logic [SIG_W-1:0] POW3_4  = 26'd81;
    localparam logic [SIG_W-1:0] POW3_8  = 26'd6561;
    localparam logic [SIG_W-1:0] POW3_12 = 26'd531441;
    localparam logic [SIG_W-1:0] POW3_16 = 26'd43046721;

    // register map, word index (byte address 4 * index)
    typedef enum logic [2:0] {
        REG_EPSILON    = 3'd0,
        REG_LINE_WIDTH = 3'd1,
        REG_ROI_LEFT   = 3'd2,
        REG_ROI_RIGHT  = 3'd3,
        REG_ROI_TOP    = 3'd4,
        REG_ROI_BOTTOM = 3'd5
    } cfg_reg_t;

    // centre pixel, its 16 neighbours (census order) and its position
    typedef struct packed {
        logic [POS_W-1:0]               cr;
        logic [POS_W-1:0]               cc;
        logic [NB_NUM-1:0][PIX_W-1:0]   nb;
        logic [PIX_W-1:0]               centre;
    } patch_t;

endpackage

>>> rtl/core/tcs_linebuf.sv
// ----------------------------------------------------------------------------
// Ternary census signature: line store
// One word per image column holding that column's pixels of the stored
// lines. Single write port, registered read port, write-first on a
// same-address collision.
// ----------------------------------------------------------------------------
module tcs_linebuf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port; a word written at the same edge is passed straight on
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tcs_front.sv
// ----------------------------------------------------------------------------
// Ternary census signature: front end
// Position counters, region check, line store access and the sliding
// window. Hands one patch per eligible centre to the census datapath.
// ----------------------------------------------------------------------------
module tcs_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int OUTER_DIST = 2,
    parameter int INNER_DIST = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // pixel words in
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [tcs_pkg::PIX_W-1:0] s_pix,
    input  logic                      s_fs,
    // settings
    input  logic [10:0]               line_width,
    input  logic [9:0]                roi_left,
    input  logic [10:0]               roi_right,
    input  logic [9:0]                roi_top,
    input  logic [10:0]               roi_bottom,
    // patches out
    output logic                      p_valid,
    input  logic                      p_ready,
    output tcs_pkg::patch_t           p_data
);

    localparam int SPAN   = (OUTER_DIST > INNER_DIST) ? OUTER_DIST : INNER_DIST;
    localparam int WSZ    = 2 * SPAN + 1;
    localparam int NLINES = 2 * SPAN;
    localparam int PW     = tcs_pkg::PIX_W;
    localparam int DW     = PW * NLINES;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CWX    = CW + 1;
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int LWW    = (CWX > 11) ? CWX : 11;
    localparam int MW     = (CW > RW) ? CW : RW;
    localparam int EW     = ((MW > 11) ? MW : 11) + 2;
    localparam int POSW   = tcs_pkg::POS_W;

    // neighbour offsets in census order
    localparam int DY [16] = '{-OUTER_DIST, -OUTER_DIST, -OUTER_DIST,
                               -INNER_DIST, -INNER_DIST, -INNER_DIST,
                               0, 0, 0, 0,
                               INNER_DIST, INNER_DIST, INNER_DIST,
                               OUTER_DIST, OUTER_DIST, OUTER_DIST};
    localparam int DX [16] = '{-OUTER_DIST, 0, OUTER_DIST,
                               -INNER_DIST, 0, INNER_DIST,
                               -OUTER_DIST, -INNER_DIST, INNER_DIST, OUTER_DIST,
                               -INNER_DIST, 0, INNER_DIST,
                               -OUTER_DIST, 0, OUTER_DIST};

    logic            accept;
    logic [CW-1:0]   col_reg, col_next, col_cur;
    logic [RW-1:0]   row_reg, row_next, row_cur;
    logic [LWW-1:0]  lw_wide;
    logic [CWX-1:0]  lw_eff;
    logic            col_wrap;
    logic            elig;

    logic            s1_valid_reg, s1_valid_next;
    logic [PW-1:0]   s1_pix_reg;
    logic [CW-1:0]   s1_col_reg;
    logic            s1_elig_reg;
    logic [POSW-1:0] s1_cc_reg;
    logic [POSW-1:0] s1_cr_reg;
    logic            s1_adv;

    logic            p_load;
    logic            p_valid_reg, p_valid_next;
    tcs_pkg::patch_t p_data_reg, p_data_next;

    logic [DW-1:0]   rd_word;
    logic [DW-1:0]   wr_word;
    logic [PW-1:0]   colv [WSZ];
    logic [PW-1:0]   win_reg [WSZ][WSZ];
    logic [tcs_pkg::NB_NUM-1:0][PW-1:0] nb_next;

    // handshake through the two stages
    assign p_load  = !p_valid_reg || p_ready;
    assign s1_adv  = s1_valid_reg && p_load;
    assign s_ready = !s1_valid_reg || p_load;
    assign accept  = s_valid && s_ready;

    // position of the arriving pixel and the next one
    assign col_cur = s_fs ? '0 : col_reg;
    assign row_cur = s_fs ? '0 : row_reg;
    assign lw_wide = LWW'(line_width);

    always_comb begin
        if (line_width == 11'd0) begin
            lw_eff = CWX'(1);
        end else if (lw_wide > LWW'(MAX_WIDTH)) begin
            lw_eff = CWX'(MAX_WIDTH);
        end else begin
            lw_eff = CWX'(line_width);
        end
    end

    assign col_wrap = (CWX'(col_cur) + CWX'(1)) >= lw_eff;

    always_comb begin
        col_next = CW'(col_cur + CW'(1));
        row_next = row_cur;
        if (col_wrap) begin
            col_next = '0;
            if (row_cur != RW'(MAX_ROWS - 1)) begin
                row_next = RW'(row_cur + RW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // centre lies SPAN behind the pixel; check it against the shrunk region
    assign elig = (EW'(col_cur) >= EW'(roi_left) + EW'(OUTER_DIST + SPAN))
               && (EW'(col_cur) + EW'(OUTER_DIST + 1) <= EW'(roi_right) + EW'(SPAN))
               && (EW'(row_cur) >= EW'(roi_top) + EW'(OUTER_DIST + SPAN))
               && (EW'(row_cur) + EW'(OUTER_DIST + 1) <= EW'(roi_bottom) + EW'(SPAN));

    // stage 1: pixel waits here for its line store column
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_pix;
            s1_col_reg  <= col_cur;
            s1_elig_reg <= elig;
            s1_cc_reg   <= POSW'(col_cur) - POSW'(SPAN);
            s1_cr_reg   <= POSW'(row_cur) - POSW'(SPAN);
        end
    end

    // new window column: stored lines oldest first, then the new pixel
    always_comb begin
        for (int k = 0; k < NLINES; k++) begin
            colv[k] = rd_word[k*PW +: PW];
        end
        colv[NLINES] = s1_pix_reg;
        for (int k = 0; k < NLINES; k++) begin
            wr_word[k*PW +: PW] = colv[k+1];
        end
    end

    tcs_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (DW)
    ) u_linebuf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (rd_word),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word)
    );

    // window shifts one column per pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int y = 0; y < WSZ; y++) begin
                for (int x = 0; x < WSZ; x++) begin
                    win_reg[y][x] <= '0;
                end
            end
        end else if (s1_adv) begin
            for (int y = 0; y < WSZ; y++) begin
                for (int x = 0; x < WSZ - 1; x++) begin
                    win_reg[y][x] <= win_reg[y][x+1];
                end
                win_reg[y][WSZ-1] <= colv[y];
            end
        end
    end

    // neighbours as they stand in the window after this shift
    for (genvar k = 0; k < tcs_pkg::NB_NUM; k++) begin : g_nb
        localparam int YY = SPAN + DY[k];
        localparam int XX = SPAN + DX[k];
        if (XX == WSZ - 1) begin : g_new
            assign nb_next[k] = colv[YY];
        end else begin : g_old
            assign nb_next[k] = win_reg[YY][XX+1];
        end
    end

    always_comb begin
        p_data_next.centre = win_reg[SPAN][SPAN+1];
        p_data_next.nb     = nb_next;
        p_data_next.cc     = s1_cc_reg;
        p_data_next.cr     = s1_cr_reg;
    end

    // stage 2: patch register towards the census datapath
    always_comb begin
        p_valid_next = p_valid_reg;
        if (p_load) begin
            p_valid_next = s1_valid_reg && s1_elig_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            p_data_reg <= p_data_next;
        end
    end

    assign p_valid = p_valid_reg;
    assign p_data  = p_data_reg;

    // an accepted word always lands in stage 1
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted pixel missing from stage 1");

    // column counter never leaves the line store
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= CW'(MAX_WIDTH - 1))
        else $error("column counter out of range");

endmodule

>>> rtl/core/tcs_census.sv
// ----------------------------------------------------------------------------
// Ternary census signature: census datapath
// Thresholds, 16 ternary digits and the corner test in one stage, the
// base-3 join in the result register.
// ----------------------------------------------------------------------------
module tcs_census (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [7:0]                epsilon,
    // patches in
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tcs_pkg::patch_t           in_data,
    // results out
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tcs_pkg::SIG_W-1:0] out_sig,
    output logic [tcs_pkg::POS_W-1:0] out_cc,
    output logic [tcs_pkg::POS_W-1:0] out_cr
);

    localparam int PW   = tcs_pkg::PIX_W;
    localparam int GW   = tcs_pkg::GRP_W;
    localparam int SW   = tcs_pkg::SIG_W;
    localparam int POSW = tcs_pkg::POS_W;

    // digit codes
    localparam logic [1:0] DIG_SAME  = 2'd0;
    localparam logic [1:0] DIG_ABOVE = 2'd1;
    localparam logic [1:0] DIG_BELOW = 2'd2;

    logic [PW-1:0]   lo, hi;
    logic [PW:0]     hi_sum;
    logic [1:0]      dig [tcs_pkg::NB_NUM];
    logic            corner_hit;
    logic [GW-1:0]   grp_next [4];

    logic            a_load;
    logic            a_valid_reg, a_valid_next;
    logic [GW-1:0]   grp_reg [4];
    logic [POSW-1:0] a_cc_reg, a_cr_reg;

    logic            o_load;
    logic            o_valid_reg, o_valid_next;
    logic [SW-1:0]   sig_next;
    logic [SW-1:0]   sig_reg;
    logic [POSW-1:0] o_cc_reg, o_cr_reg;

    // saturating thresholds around the centre
    assign lo     = (in_data.centre > epsilon) ? (in_data.centre - epsilon) : '0;
    assign hi_sum = {1'b0, in_data.centre} + {1'b0, epsilon};
    assign hi     = hi_sum[PW] ? {PW{1'b1}} : hi_sum[PW-1:0];

    // one digit per neighbour
    always_comb begin
        for (int k = 0; k < tcs_pkg::NB_NUM; k++) begin
            if (in_data.nb[k] > hi) begin
                dig[k] = DIG_ABOVE;
            end else if (in_data.nb[k] < lo) begin
                dig[k] = DIG_BELOW;
            end else begin
                dig[k] = DIG_SAME;
            end
        end
    end

    // outer corners are digits 0, 2, 13 and 15
    assign corner_hit = (dig[0] != DIG_SAME) || (dig[2] != DIG_SAME)
                     || (dig[13] != DIG_SAME) || (dig[15] != DIG_SAME);

    // four digits per group, least significant first
    always_comb begin
        for (int g = 0; g < 4; g++) begin
            grp_next[g] = GW'(dig[4*g])
                        + GW'(dig[4*g+1]) * GW'(3)
                        + GW'(dig[4*g+2]) * GW'(9)
                        + GW'(dig[4*g+3]) * GW'(27);
        end
    end

    // digit stage
    assign o_load   = !o_valid_reg || out_ready;
    assign a_load   = !a_valid_reg || o_load;
    assign in_ready = a_load;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_load) begin
            a_valid_next = in_valid && corner_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load && in_valid) begin
            for (int g = 0; g < 4; g++) begin
                grp_reg[g] <= grp_next[g];
            end
            a_cc_reg <= in_data.cc;
            a_cr_reg <= in_data.cr;
        end
    end

    // result register: join the groups in base 3
    assign sig_next = SW'(grp_reg[0])
                    + SW'(grp_reg[1]) * tcs_pkg::POW3_4
                    + SW'(grp_reg[2]) * tcs_pkg::POW3_8
                    + SW'(grp_reg[3]) * tcs_pkg::POW3_12;

    always_comb begin
        o_valid_next = o_valid_reg;
        if (o_load) begin
            o_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load && a_valid_reg) begin
            sig_reg  <= sig_next;
            o_cc_reg <= a_cc_reg;
            o_cr_reg <= a_cr_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_sig   = sig_reg;
    assign out_cc    = o_cc_reg;
    assign out_cr    = o_cr_reg;

    // a digit word moving on always shows up as a result
    a_digit_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && o_load) |=> o_valid_reg)
        else $error("digit word lost before the result register");

    // signature stays a 16-digit base-3 number
    a_sig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg |-> (sig_reg < tcs_pkg::POW3_16))
        else $error("signature out of range");

    // some outer corner was non-zero, so the code is never zero
    a_sig_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg |-> (sig_reg != '0))
        else $error("result with all outer corners similar");

endmodule

>>> rtl/core/ternary_census_signature.sv
// ----------------------------------------------------------------------------
// Ternary census signature generator (16 neighbours)
// Streams grey pixels in raster order and emits a base-3 census code for
// every centre of the region of interest whose outer corners are not all
// similar to it.
//
// s_ side: one pixel word per handshake; s_tuser marks the first pixel of a
// frame and sends the position counters to column 0, row 0.
// m_ side: one signature word per qualifying centre, in raster order of the
// centres, which lie two lines and two columns behind the arriving pixel.
// APB port: epsilon, line width and region bounds at byte addresses 0..20;
// the user must write them only while no pixel is in flight, which the block
// does not enforce; pready is always high. Throughput is one pixel per clock
// when the output is not stalled: each pixel costs one read and one write of
// the line memory, which is one column-wide word per address.
// Reset clears counters, window and all valid flags and loads the default
// settings; the line memory is not cleared and needs no clearing pass.
// When m_tready is low the result is held; the pipeline keeps taking pixels
// until its empty stages have filled, then s_tready falls.
// ----------------------------------------------------------------------------
module ternary_census_signature #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int OUTER_DIST = 2,
    parameter int INNER_DIST = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] frame_start
    // signature stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [25:0] signature, [35:26] center_column,
                                   // [45:36] center_row, [47:46] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tcs_pkg::cfg_reg_t reg_sel;
    logic            cfg_wr;
    logic [7:0]      epsilon_reg;
    logic [10:0]     line_width_reg;
    logic [9:0]      roi_left_reg;
    logic [10:0]     roi_right_reg;
    logic [9:0]      roi_top_reg;
    logic [10:0]     roi_bottom_reg;

    logic            p_valid;
    logic            p_ready;
    tcs_pkg::patch_t p_data;
    logic [tcs_pkg::SIG_W-1:0] sig;
    logic [tcs_pkg::POS_W-1:0] cc;
    logic [tcs_pkg::POS_W-1:0] cr;

    // APB register file
    assign pready  = 1'b1;
    assign reg_sel = tcs_pkg::cfg_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epsilon_reg    <= 8'd0;
            line_width_reg <= 11'd640;
            roi_left_reg   <= 10'd0;
            roi_right_reg  <= 11'd640;
            roi_top_reg    <= 10'd0;
            roi_bottom_reg <= 11'd480;
        end else if (cfg_wr) begin
            case (reg_sel)
                tcs_pkg::REG_EPSILON:    epsilon_reg    <= pwdata[7:0];
                tcs_pkg::REG_LINE_WIDTH: line_width_reg <= pwdata[10:0];
                tcs_pkg::REG_ROI_LEFT:   roi_left_reg   <= pwdata[9:0];
                tcs_pkg::REG_ROI_RIGHT:  roi_right_reg  <= pwdata[10:0];
                tcs_pkg::REG_ROI_TOP:    roi_top_reg    <= pwdata[9:0];
                tcs_pkg::REG_ROI_BOTTOM: roi_bottom_reg <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_sel)
            tcs_pkg::REG_EPSILON:    prdata = {24'd0, epsilon_reg};
            tcs_pkg::REG_LINE_WIDTH: prdata = {21'd0, line_width_reg};
            tcs_pkg::REG_ROI_LEFT:   prdata = {22'd0, roi_left_reg};
            tcs_pkg::REG_ROI_RIGHT:  prdata = {21'd0, roi_right_reg};
            tcs_pkg::REG_ROI_TOP:    prdata = {22'd0, roi_top_reg};
            tcs_pkg::REG_ROI_BOTTOM: prdata = {21'd0, roi_bottom_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // window front end
    tcs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_ROWS   (MAX_ROWS),
        .OUTER_DIST (OUTER_DIST),
        .INNER_DIST (INNER_DIST)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_pix      (s_tdata),
        .s_fs       (s_tuser),
        .line_width (line_width_reg),
        .roi_left   (roi_left_reg),
        .roi_right  (roi_right_reg),
        .roi_top    (roi_top_reg),
        .roi_bottom (roi_bottom_reg),
        .p_valid    (p_valid),
        .p_ready    (p_ready),
        .p_data     (p_data)
    );

    // census datapath
    tcs_census u_census (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .epsilon   (epsilon_reg),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_data   (p_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sig   (sig),
        .out_cc    (cc),
        .out_cr    (cr)
    );

    assign m_tdata = {2'b00, cr, cc, sig};

endmodule

>>> tb/sv/tb_ternary_census_signature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ternary census signature: self-checking regression
// Streams grey frames into the block under bursty input and a stalling
// result side, predicts every census signature from a local line store and
// window, and compares each result word field by field. Registers are
// rewritten over APB between frames and read back.
// ----------------------------------------------------------------------------
module tb_ternary_census_signature;

    localparam int OUTER       = 2;
    localparam int INNER       = 1;
    localparam int SPAN        = 2;
    localparam int LINE_MAX    = 1024;
    localparam int ROW_MAX     = 1024;
    localparam int DRAIN_WAIT  = 8;     // pipeline depth plus margin
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int RAND_ITEMS  = 220;

    // neighbour offsets in census digit order
    localparam int NB_ROW [16] = '{-OUTER, -OUTER, -OUTER, -INNER, -INNER, -INNER,
                                   0, 0, 0, 0, INNER, INNER, INNER, OUTER, OUTER, OUTER};
    localparam int NB_COL [16] = '{-OUTER, 0, OUTER, -INNER, 0, INNER,
                                   -OUTER, -INNER, INNER, OUTER, -INNER, 0, INNER,
                                   -OUTER, 0, OUTER};

    // hand-made 5 x 7 frame: similar corners, above, below and the extremes
    localparam logic [7:0] GRID [35] = '{
        8'd128, 8'd0,   8'd255, 8'd128, 8'd128,
        8'd0,   8'd129, 8'd127, 8'd128, 8'd255,
        8'd128, 8'd255, 8'd128, 8'd0,   8'd128,
        8'd127, 8'd128, 8'd0,   8'd128, 8'd0,
        8'd128, 8'd0,   8'd255, 8'd255, 8'd128,
        8'd0,   8'd127, 8'd128, 8'd129, 8'd255,
        8'd128, 8'd128, 8'd255, 8'd0,   8'd128};

    typedef struct packed {
        logic [tcs_pkg::POS_W-1:0] cr;
        logic [tcs_pkg::POS_W-1:0] cc;
        logic [tcs_pkg::SIG_W-1:0] sig;
    } census_word_t;

    function automatic logic [31:0] reg_mask(tcs_pkg::cfg_reg_t idx);
        case (idx)
            tcs_pkg::REG_EPSILON:                          return 32'h0FF;
            tcs_pkg::REG_ROI_LEFT, tcs_pkg::REG_ROI_TOP:   return 32'h3FF;
            default:                                       return 32'h7FF;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: census predictor plus queue of awaited signature words
    // ------------------------------------------------------------------------
    class census_scoreboard;
        bit [7:0]  line_mem [4][LINE_MAX];
        bit [7:0]  win [5][5];
        bit [9:0]  col_cnt;
        bit [9:0]  row_cnt;
        bit [7:0]  eps      = 8'd0;
        bit [10:0] line_w   = 11'd640;
        bit [9:0]  roi_l    = 10'd0;
        bit [10:0] roi_r    = 11'd640;
        bit [9:0]  roi_t    = 10'd0;
        bit [10:0] roi_b    = 11'd480;
        census_word_t awaited_sigs [$];
        int errors = 0;

        function int pending();
            return awaited_sigs.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(tcs_pkg::cfg_reg_t idx, logic [31:0] val);
            case (idx)
                tcs_pkg::REG_EPSILON:    eps    = val[7:0];
                tcs_pkg::REG_LINE_WIDTH: line_w = val[10:0];
                tcs_pkg::REG_ROI_LEFT:   roi_l  = val[9:0];
                tcs_pkg::REG_ROI_RIGHT:  roi_r  = val[10:0];
                tcs_pkg::REG_ROI_TOP:    roi_t  = val[9:0];
                tcs_pkg::REG_ROI_BOTTOM: roi_b  = val[10:0];
                default: ;
            endcase
        endfunction

        // one accepted pixel word: shift stores and window, maybe expect a signature
        function void note_pixel(logic [7:0] pix, logic fs);
            bit [7:0] fresh [5];
            int dig [16];
            int c, r, cc, cr, ctr, lo, hi, lim, nbv, sig, wt;
            census_word_t exp_w;
            if (fs) begin
                col_cnt = '0;
                row_cnt = '0;
            end
            c = int'(col_cnt);
            r = int'(row_cnt);
            for (int k = 0; k < 4; k++) fresh[k] = line_mem[k][c];
            fresh[4] = pix;
            for (int k = 0; k < 4; k++) line_mem[k][c] = fresh[k+1];
            for (int y = 0; y < 5; y++) begin
                for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
                win[y][4] = fresh[y];
            end

            if (c >= SPAN && r >= SPAN) begin
                cc = c - SPAN;
                cr = r - SPAN;
                if (cc >= int'(roi_l) + OUTER && cc <= int'(roi_r) - (OUTER + 1) &&
                    cr >= int'(roi_t) + OUTER && cr <= int'(roi_b) - (OUTER + 1)) begin
                    ctr = int'(win[SPAN][SPAN]);
                    // thresholds clamp to the pixel range
                    lo  = (ctr > int'(eps)) ? ctr - int'(eps) : 0;
                    hi  = (ctr + int'(eps) > 255) ? 255 : ctr + int'(eps);
                    for (int k = 0; k < 16; k++) begin
                        nbv = int'(win[SPAN+NB_ROW[k]][SPAN+NB_COL[k]]);
                        dig[k] = (nbv > hi) ? 1 : (nbv < lo) ? 2 : 0;
                    end
                    // all four outer corners similar: nothing emitted
                    if ((dig[0] | dig[2] | dig[13] | dig[15]) != 0) begin
                        sig = 0;
                        wt  = 1;
                        for (int k = 0; k < 16; k++) begin
                            sig += dig[k] * wt;
                            wt  *= 3;
                        end
                        exp_w.sig = sig[tcs_pkg::SIG_W-1:0];
                        exp_w.cc  = cc[tcs_pkg::POS_W-1:0];
                        exp_w.cr  = cr[tcs_pkg::POS_W-1:0];
                        awaited_sigs.push_back(exp_w);
                    end
                end
            end

            // position advance; width 0 acts as 1, oversize as the full line
            lim = (line_w == 0) ? 1 : (int'(line_w) > LINE_MAX) ? LINE_MAX : int'(line_w);
            if (c + 1 >= lim) begin
                col_cnt = '0;
                if (r + 1 < ROW_MAX) row_cnt = 10'(r + 1);
            end else begin
                col_cnt = 10'(c + 1);
            end
        endfunction

        task check_signature(logic [47:0] data);
            census_word_t exp_w;
            if (awaited_sigs.size() == 0) begin
                report($sformatf("unexpected word %h", data));
            end else begin
                exp_w = awaited_sigs.pop_front();
                if (data[25:0] !== exp_w.sig)
                    report($sformatf("signature %0d, want %0d", data[25:0], exp_w.sig));
                if (data[35:26] !== exp_w.cc)
                    report($sformatf("centre column %0d, want %0d", data[35:26], exp_w.cc));
                if (data[45:36] !== exp_w.cr)
                    report($sformatf("centre row %0d, want %0d", data[45:36], exp_w.cr));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pixel
    logic        s_tuser;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [25:0] signature, [35:26] centre column, [45:36] centre row
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ternary_census_signature u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    census_scoreboard sb;
    int burst_left = 0;
    bit steady     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Monitor: note accepted pixels, check accepted signature words
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_pixel(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_signature(m_tdata);
        end
    end

    // watchdog on cycles with no handshake anywhere
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ternary_census_signature regression: fail");
                $finish;
            end
        end
    end

    // result side: stall pattern switching between a few modes
    int rx_mode     = 0;
    int rx_mode_left = 0;
    int rx_run      = 0;
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ~m_tready;
            default: begin
                // runs of ready and stall, each of random length
                if (rx_run == 0) begin
                    rx_run = $urandom_range(1, 8);
                    m_tready <= ~m_tready;
                end
                rx_run--;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Drivers; every task starts and ends on a falling edge
    // ------------------------------------------------------------------------
    task automatic push_pixel(input logic [7:0] pix, input logic fs);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        @(negedge aclk);
    endtask

    // stop the stream and let every awaited word and the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input tcs_pkg::cfg_reg_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // write a register, then read it back
    task automatic write_reg(input tcs_pkg::cfg_reg_t idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_access(1'b1, idx, val, rd);
        sb.set_reg(idx, val);
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== (val & reg_mask(idx)))
            sb.report($sformatf("register %s reads %h, want %h", idx.name(), rd,
                                val & reg_mask(idx)));
    endtask

    task automatic configure(input int eps, input int lw, input int rl, input int rr,
                             input int rt, input int rb);
        write_reg(tcs_pkg::REG_EPSILON,    32'(eps));
        write_reg(tcs_pkg::REG_LINE_WIDTH, 32'(lw));
        write_reg(tcs_pkg::REG_ROI_LEFT,   32'(rl));
        write_reg(tcs_pkg::REG_ROI_RIGHT,  32'(rr));
        write_reg(tcs_pkg::REG_ROI_TOP,    32'(rt));
        write_reg(tcs_pkg::REG_ROI_BOTTOM, 32'(rb));
        apb_idle();
    endtask

    // pixel content: uniform, noise around a base level, or sparse spikes
    function automatic logic [7:0] pick_pixel(int style, int base, int spread);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = base + $urandom_range(0, 2 * spread) - spread;
            default: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : base;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int rand_items;
        int eps, w, rl, rr, rt, rb, total, style, base, spread;
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 5'd0;
        pwdata   <= 32'd0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // hand-made frame, five pixels wide, exact thresholds
        configure(0, 5, 0, 5, 0, 1024);
        for (int i = 0; i < 35; i++) push_pixel(GRID[i], i == 0);
        settle();

        // width zero behaves as one: every word starts a new row
        configure(20, 0, 0, 1024, 0, 1024);
        for (int i = 0; i < 30; i++) push_pixel(8'($urandom_range(0, 255)), i == 0);
        settle();

        // inverted region, full-width line, widest margin: no signatures
        configure(255, 1024, 1023, 0, 1023, 0);
        for (int i = 0; i < 40; i++) push_pixel(8'($urandom_range(0, 255)), i == 0);
        settle();

        // line width shrinks in the middle of a line
        configure(6, 12, 0, 12, 0, 2047);
        base = $urandom_range(0, 255);
        for (int i = 0; i < 6 * 12 + 9; i++) push_pixel(pick_pixel(1, base, 12), i == 0);
        settle();
        write_reg(tcs_pkg::REG_LINE_WIDTH, 32'd6);
        apb_idle();
        for (int i = 0; i < 6 * 6; i++) push_pixel(pick_pixel(1, base, 12), 1'b0);
        settle();

        // random frames with mostly sane settings and some broken frames
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       eps = 0;
                1:       eps = 255;
                2, 3:    eps = $urandom_range(1, 12);
                default: eps = $urandom_range(0, 255);
            endcase
            w  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
            rl = $urandom_range(0, 3);
            rr = $urandom_range(rl + 4, 18);
            rt = $urandom_range(0, 3);
            rb = $urandom_range(rt + 4, 12);
            if ($urandom_range(0, 7) == 0) begin
                rl = $urandom_range(0, 20);
                rr = $urandom_range(0, 20);
                rt = $urandom_range(0, 12);
                rb = $urandom_range(0, 12);
            end
            configure(eps, w, rl, rr, rt, rb);
            steady = ($urandom_range(0, 3) == 0);
            style  = $urandom_range(0, 2);
            base   = $urandom_range(0, 255);
            spread = $urandom_range(0, eps + 3);
            total  = $urandom_range(5, 9) * w + $urandom_range(0, w - 1);
            for (int i = 0; i < total; i++)
                push_pixel(pick_pixel(style, base, spread),
                           (i == 0) || ($urandom_range(0, 39) == 0));
            rand_items += total;
            settle();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d signatures never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("ternary_census_signature regression: pass");
        end else begin
            $display("ternary_census_signature regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tcs_pkg.sv
rtl/core/tcs_linebuf.sv
rtl/core/tcs_front.sv
rtl/core/tcs_census.sv
rtl/core/ternary_census_signature.sv
tb/sv/tb_ternary_census_signature.sv
